### design/tlsi_pkg.sv
// shared types and codes for the three-list sorted intersection unit
`timescale 1ns / 1ps
`default_nettype none
package tlsi_pkg;

  // command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RUN  = 1'b1;

  // list selector codes
  localparam logic [1:0] LIST_FIRST  = 2'd0;
  localparam logic [1:0] LIST_SECOND = 2'd1;
  localparam logic [1:0] LIST_THIRD  = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } tlsi_state_t;

  // outcome of one compare step on the three heads
  typedef struct packed {
    logic all_eq;
    logic adv_a;
    logic adv_b;
    logic adv_c;
  } tlsi_step_t;

endpackage
`default_nettype wire

### design/tlsi_list_mem.sv
// one list store: single write port, single registered read port
`timescale 1ns / 1ps
`default_nettype none
module tlsi_list_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = 6
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### design/tlsi_cmp.sv
// shared compare unit: finds the smallest of three signed heads
`timescale 1ns / 1ps
`default_nettype none
module tlsi_cmp #(
  parameter int WIDTH = 32
) (
  input  wire logic signed [WIDTH-1:0] a,
  input  wire logic signed [WIDTH-1:0] b,
  input  wire logic signed [WIDTH-1:0] c,
  output tlsi_pkg::tlsi_step_t         step
);
  import tlsi_pkg::*;

  logic a_le_b, a_le_c, b_le_c;

  always_comb begin
    a_le_b      = (a <= b);
    a_le_c      = (a <= c);
    b_le_c      = (b <= c);
    // a head advances when it equals the minimum; equal heads all advance
    step.adv_a  = a_le_b && a_le_c;
    step.adv_b  = (b <= a) && b_le_c;
    step.adv_c  = (c <= a) && (c <= b);
    step.all_eq = (a == b) && (a == c);
  end

endmodule
`default_nettype wire

### design/three_list_sorted_intersection_unit.sv
// top level: list loading, walk sequencer and result output register
// load: busy stays low, no result.
// run: one compare step per cycle after a registered memory read, set by the single
//   shared compare unit and the one read port per list; the number of steps is at
//   most the sum of the three list lengths.
// each word shows the cycle after the next match or walk end; receiver never stalls
// rst (synchronous) clears list lengths, overflow flag and the sequencer.
`timescale 1ns / 1ps
`default_nettype none
module three_list_sorted_intersection_unit #(
  parameter int LIST_DEPTH  = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          command,
  input  wire logic        [1:0]             list_select,
  input  wire logic signed [VALUE_WIDTH-1:0] value,
  output logic                               strobe,
  output logic signed      [VALUE_WIDTH-1:0] common_value,
  output logic                               found,
  output logic                               overflow,
  output logic                               last
);
  import tlsi_pkg::*;

  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam logic [CW-1:0] FULL = CW'(LIST_DEPTH);

  tlsi_state_t state, state_next;

  logic [CW-1:0] cnt_a, cnt_b, cnt_c;
  logic [CW-1:0] ia, ib, ic;
  logic [CW-1:0] ia_next, ib_next, ic_next;
  logic          dropped;
  logic          run_ovf;
  logic          pend_valid;
  logic [VALUE_WIDTH-1:0] pend_value;

  logic [VALUE_WIDTH-1:0] head_a, head_b, head_c;
  tlsi_step_t             step;

  logic load_acc, run_acc;
  logic we_a, we_b, we_c, drop;
  logic in_bounds, match, finish;
  logic emit, emit_found, emit_last;
  logic [VALUE_WIDTH-1:0] emit_value;

  assign busy     = (state != ST_IDLE);
  assign load_acc = start && !busy && (command == CMD_LOAD);
  assign run_acc  = start && !busy && (command == CMD_RUN);

  assign we_a = load_acc && (list_select == LIST_FIRST)  && (cnt_a < FULL);
  assign we_b = load_acc && (list_select == LIST_SECOND) && (cnt_b < FULL);
  assign we_c = load_acc && (list_select == LIST_THIRD)  && (cnt_c < FULL);
  assign drop = load_acc && (((list_select == LIST_FIRST)  && (cnt_a == FULL)) ||
                             ((list_select == LIST_SECOND) && (cnt_b == FULL)) ||
                             ((list_select == LIST_THIRD)  && (cnt_c == FULL)));

  // read address follows the next index so the heads are ready each step
  tlsi_list_mem #(.DEPTH(LIST_DEPTH), .WIDTH(VALUE_WIDTH), .AW(AW)) u_mem_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (cnt_a[AW-1:0]),
    .wdata (value),
    .raddr (ia_next[AW-1:0]),
    .rdata (head_a)
  );

  tlsi_list_mem #(.DEPTH(LIST_DEPTH), .WIDTH(VALUE_WIDTH), .AW(AW)) u_mem_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (cnt_b[AW-1:0]),
    .wdata (value),
    .raddr (ib_next[AW-1:0]),
    .rdata (head_b)
  );

  tlsi_list_mem #(.DEPTH(LIST_DEPTH), .WIDTH(VALUE_WIDTH), .AW(AW)) u_mem_c (
    .clk   (clk),
    .we    (we_c),
    .waddr (cnt_c[AW-1:0]),
    .wdata (value),
    .raddr (ic_next[AW-1:0]),
    .rdata (head_c)
  );

  tlsi_cmp #(.WIDTH(VALUE_WIDTH)) u_cmp (
    .a    (head_a),
    .b    (head_b),
    .c    (head_c),
    .step (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ia_next    = ia;
    ib_next    = ib;
    ic_next    = ic;
    in_bounds  = 1'b0;
    match      = 1'b0;
    finish     = 1'b0;
    emit       = 1'b0;
    emit_found = 1'b0;
    emit_last  = 1'b0;
    emit_value = pend_value;
    case (state)
      ST_IDLE: begin
        ia_next = '0;
        ib_next = '0;
        ic_next = '0;
        if (run_acc) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        in_bounds = (ia < cnt_a) && (ib < cnt_b) && (ic < cnt_c);
        if (in_bounds) begin
          match   = step.all_eq;
          ia_next = ia + CW'(step.adv_a);
          ib_next = ib + CW'(step.adv_b);
          ic_next = ic + CW'(step.adv_c);
          // a held word goes out once a later match shows it is not the last
          emit       = step.all_eq && pend_valid;
          emit_found = 1'b1;
        end else begin
          finish     = 1'b1;
          emit       = 1'b1;
          emit_last  = 1'b1;
          emit_found = pend_valid;
          emit_value = pend_valid ? pend_value : '0;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ia         <= '0;
      ib         <= '0;
      ic         <= '0;
      cnt_a      <= '0;
      cnt_b      <= '0;
      cnt_c      <= '0;
      dropped    <= 1'b0;
      pend_valid <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      ia     <= ia_next;
      ib     <= ib_next;
      ic     <= ic_next;
      strobe <= emit;
      if (finish) begin
        cnt_a      <= '0;
        cnt_b      <= '0;
        cnt_c      <= '0;
        dropped    <= 1'b0;
        pend_valid <= 1'b0;
      end else begin
        if (we_a) begin
          cnt_a <= cnt_a + CW'(1);
        end
        if (we_b) begin
          cnt_b <= cnt_b + CW'(1);
        end
        if (we_c) begin
          cnt_c <= cnt_c + CW'(1);
        end
        if (drop) begin
          dropped <= 1'b1;
        end
        if (match) begin
          pend_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (run_acc) begin
      run_ovf <= dropped;
    end
    if (match) begin
      pend_value <= head_a;
    end
    if (emit) begin
      common_value <= emit_value;
      found        <= emit_found;
      overflow     <= run_ovf;
      last         <= emit_last;
    end
  end

  // an empty-intersection word is always the final one
  assert property (@(posedge clk) disable iff (rst) (strobe && !found) |-> last)
    else $error("empty result not marked last");

  // the end of a walk always hands out its final word
  assert property (@(posedge clk) disable iff (rst) $fell(busy) |-> (strobe && last))
    else $error("walk ended without a final word");

  // a word that is not the last comes while the walk is still going
  assert property (@(posedge clk) disable iff (rst) (strobe && !last) |-> busy)
    else $error("non-final word after walk end");

endmodule
`default_nettype wire

### tb/tlsi_checker.sv
// checker for the three-list sorted intersection unit: predicts and compares result words
`timescale 1ns / 1ps
module tlsi_checker #(
  parameter int LIST_DEPTH  = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          command,
  input  logic [1:0]                    list_select,
  input  logic signed [VALUE_WIDTH-1:0] value,
  input  logic                          strobe,
  input  logic signed [VALUE_WIDTH-1:0] common_value,
  input  logic                          found,
  input  logic                          overflow,
  input  logic                          last,
  output int                            mismatches,
  output int                            outstanding,
  output int                            words_checked
);
  import tlsi_pkg::*;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic                   found;
    logic                   ovf;
    logic                   last;
  } match_word_t;

  logic signed [VALUE_WIDTH-1:0] list_mem [3][LIST_DEPTH];
  int          fill [3];
  logic        dropped;
  match_word_t expected_matches [$];
  int          fail_count = 0;
  int          checked_count = 0;

  task automatic append_value(input int idx, input logic signed [VALUE_WIDTH-1:0] v);
    if (fill[idx] < LIST_DEPTH) begin
      list_mem[idx][fill[idx]] = v;
      fill[idx] = fill[idx] + 1;
    end else begin
      dropped = 1'b1;
    end
  endtask

  // add one expected word at the tail of the queue
  task automatic queue_word(input match_word_t wd);
    expected_matches = {expected_matches, wd};
  endtask

  // walk the three heads, queue one word per common value (one empty word if there is none), then clear the lists
  task automatic predict_intersection();
    int i, j, k;
    logic signed [VALUE_WIDTH-1:0] a, b, c, m;
    match_word_t prev, w;
    bit have_prev;
    i = 0;
    j = 0;
    k = 0;
    have_prev = 1'b0;
    prev = '0;
    while (i < fill[0] && j < fill[1] && k < fill[2]) begin
      a = list_mem[0][i];
      b = list_mem[1][j];
      c = list_mem[2][k];
      if (a == b && a == c) begin
        w.value = a;
        w.found = 1'b1;
        w.ovf   = dropped;
        w.last  = 1'b0;
        // hold each word back until we know whether it is the final one
        if (have_prev) queue_word(prev);
        prev = w;
        have_prev = 1'b1;
        i++;
        j++;
        k++;
      end else begin
        m = a;
        if (b < m) m = b;
        if (c < m) m = c;
        if (a == m) i++;
        if (b == m) j++;
        if (c == m) k++;
      end
    end
    if (have_prev) begin
      prev.last = 1'b1;
      queue_word(prev);
    end else begin
      w.value = '0;
      w.found = 1'b0;
      w.ovf   = dropped;
      w.last  = 1'b1;
      queue_word(w);
    end
    fill[0] = 0;
    fill[1] = 0;
    fill[2] = 0;
    dropped = 1'b0;
  endtask

  always @(posedge clk) begin
    match_word_t w;
    if (rst) begin
      fill[0] = 0;
      fill[1] = 0;
      fill[2] = 0;
      dropped = 1'b0;
    end else begin
      if (strobe) begin
        checked_count++;
        if (expected_matches.size() == 0) begin
          $display("%0t extra word: expected none, actual %0d found %b ovf %b last %b",
                   $time, common_value, found, overflow, last);
          fail_count++;
        end else begin
          w = expected_matches.pop_front();
          if (common_value !== w.value) begin
            $display("%0t common_value mismatch: expected %0d, actual %0d",
                     $time, $signed(w.value), common_value);
            fail_count++;
          end
          if (found !== w.found) begin
            $display("%0t found mismatch: expected %b, actual %b", $time, w.found, found);
            fail_count++;
          end
          if (overflow !== w.ovf) begin
            $display("%0t overflow mismatch: expected %b, actual %b", $time, w.ovf, overflow);
            fail_count++;
          end
          if (last !== w.last) begin
            $display("%0t last mismatch: expected %b, actual %b", $time, w.last, last);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        if (command == CMD_RUN) begin
          predict_intersection();
        end else if (list_select == LIST_FIRST) begin
          append_value(0, value);
        end else if (list_select == LIST_SECOND) begin
          append_value(1, value);
        end else if (list_select == LIST_THIRD) begin
          append_value(2, value);
        end
      end
    end
    outstanding   <= expected_matches.size();
    mismatches    <= fail_count;
    words_checked <= checked_count;
  end

endmodule

### tb/tb_three_list_sorted_intersection_unit.sv
// testbench top: stimulus, clock, reset and verdict for the intersection unit
`timescale 1ns / 1ps
module tb_three_list_sorted_intersection_unit;
  import tlsi_pkg::*;

  localparam int LIST_DEPTH  = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int CYCLE_LIMIT = 600000;
  localparam int ITEM_TARGET = 400;
  localparam int CALM_AFTER  = 320;
  localparam logic [1:0] LIST_NONE = 2'd3;

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic                          busy;
  logic                          command = CMD_LOAD;
  logic [1:0]                    list_select = LIST_FIRST;
  logic signed [VALUE_WIDTH-1:0] value = '0;
  logic                          strobe;
  logic signed [VALUE_WIDTH-1:0] common_value;
  logic                          found;
  logic                          overflow;
  logic                          last;

  int mismatches;
  int outstanding;
  int words_checked;
  int cycle_count = 0;
  int loads_sent = 0;
  int runs_sent = 0;
  int ignored_sent = 0;
  int overflow_sets = 0;
  bit idling_on = 1'b1;

  three_list_sorted_intersection_unit #(
    .LIST_DEPTH (LIST_DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .command     (command),
    .list_select (list_select),
    .value       (value),
    .strobe      (strobe),
    .common_value(common_value),
    .found       (found),
    .overflow    (overflow),
    .last        (last)
  );

  tlsi_checker #(
    .LIST_DEPTH (LIST_DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .list_select  (list_select),
    .value        (value),
    .strobe       (strobe),
    .common_value (common_value),
    .found        (found),
    .overflow     (overflow),
    .last         (last),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .words_checked(words_checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_three_list_sorted_intersection_unit NOT OK");
      $finish;
    end
  end

  // present one word and hold it until the unit takes it
  task automatic drive_word(input logic cmd, input logic [1:0] sel,
                            input logic signed [VALUE_WIDTH-1:0] val);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      start       <= 1'b0;
      command     <= 1'($urandom);
      list_select <= 2'($urandom);
      value       <= $urandom;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    start       <= 1'b1;
    command     <= cmd;
    list_select <= sel;
    value       <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (cmd == CMD_RUN) runs_sent++;
    else if (sel == LIST_NONE) ignored_sent++;
    else loads_sent++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    logic signed [VALUE_WIDTH-1:0] extremes [5];
    extremes[0] = 32'sh8000_0000;
    extremes[1] = -32'sd1;
    extremes[2] = 32'sd0;
    extremes[3] = 32'sd1;
    extremes[4] = 32'sh7fff_ffff;
    // run on empty lists
    drive_word(CMD_RUN, LIST_FIRST, 32'sd0);
    // both ends of the signed range in every list
    for (int e = 0; e < 5; e++) begin
      drive_word(CMD_LOAD, LIST_FIRST, extremes[e]);
      drive_word(CMD_LOAD, LIST_SECOND, extremes[e]);
      drive_word(CMD_LOAD, LIST_THIRD, extremes[e]);
    end
    // unused selector must not land anywhere
    drive_word(CMD_LOAD, LIST_NONE, 32'sd5);
    drive_word(CMD_RUN, LIST_NONE, 32'sh7fff_ffff);
    // unsorted first list, no common value
    drive_word(CMD_LOAD, LIST_FIRST, 32'sd5);
    drive_word(CMD_LOAD, LIST_FIRST, 32'sd2);
    drive_word(CMD_LOAD, LIST_SECOND, 32'sd2);
    drive_word(CMD_LOAD, LIST_THIRD, 32'sd2);
    drive_word(CMD_RUN, LIST_SECOND, -32'sd1);
  endtask

  // one data set: shared non-decreasing sequence, random subsets per list, then a run
  task automatic load_and_run_set(input int set_no);
    logic signed [VALUE_WIDTH-1:0] seq [72];
    logic signed [VALUE_WIDTH-1:0] list_vals [3][72];
    int len [3];
    int ptr [3];
    int n_seq, r, l;
    bit identical, noise;
    r = $urandom_range(0, 99);
    if (set_no == 2) n_seq = 66;
    else if (r < 85) n_seq = $urandom_range(0, 8);
    else if (r < 95) n_seq = $urandom_range(9, 24);
    else n_seq = $urandom_range(60, 68);
    identical = (set_no == 2) || (n_seq >= 60) || ($urandom_range(0, 9) == 0);
    noise = ($urandom_range(0, 7) == 0);
    seq[0] = $urandom;
    for (int e = 1; e < n_seq; e++) seq[e] = seq[e-1] + $urandom_range(0, 3);
    for (int s = 0; s < 3; s++) begin
      len[s] = 0;
      ptr[s] = 0;
      for (int e = 0; e < n_seq; e++) begin
        if (identical || $urandom_range(0, 99) < 70) begin
          list_vals[s][len[s]] = (noise && $urandom_range(0, 3) == 0) ? $urandom : seq[e];
          len[s]++;
        end
      end
    end
    if (len[0] > LIST_DEPTH || len[1] > LIST_DEPTH || len[2] > LIST_DEPTH) overflow_sets++;
    while (ptr[0] < len[0] || ptr[1] < len[1] || ptr[2] < len[2]) begin
      l = $urandom_range(0, 2);
      if (ptr[l] < len[l]) begin
        drive_word(CMD_LOAD, 2'(l), list_vals[l][ptr[l]]);
        ptr[l]++;
      end
      if ($urandom_range(0, 24) == 0) drive_word(CMD_LOAD, LIST_NONE, $urandom);
    end
    drive_word(CMD_RUN, 2'($urandom), $urandom);
    // run again on the cleared lists now and then
    if ($urandom_range(0, 9) == 0) drive_word(CMD_RUN, 2'($urandom), $urandom);
    if (set_no == 1 || $urandom_range(0, 9) == 0) wait_drained();
  endtask

  initial begin
    int set_no;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    set_no = 0;
    while (loads_sent + runs_sent < ITEM_TARGET) begin
      if (loads_sent + runs_sent >= CALM_AFTER) idling_on = 1'b0;
      else idling_on = ($urandom_range(0, 3) != 0);
      load_and_run_set(set_no);
      set_no++;
    end
    wait_drained();
    repeat (20) @(posedge clk);
    $display("covered %0d loads, %0d ignored loads, %0d runs over %0d data sets",
             loads_sent, ignored_sent, runs_sent, set_no);
    $display("checked %0d result words, %0d sets overfilled a list", words_checked,
             overflow_sets);
    if (mismatches == 0) begin
      $display("tb_three_list_sorted_intersection_unit OK");
    end else begin
      $display("tb_three_list_sorted_intersection_unit NOT OK");
    end
    $finish;
  end

endmodule
